FILE: hw/rtl/irled_pkg.sv
// irled_pkg: shared types, codes and constants of the ir and serial led controller
// no dependencies; used by the register block, the top level and the checker
package irled_pkg;

    localparam int CODE_BITS_DEF = 12;
    localparam int IR_CODE_W     = 12;

    // register reset values
    localparam logic [15:0] START_THR_RST   = 16'd2000;
    localparam logic [15:0] ONE_THR_RST     = 16'd1000;
    localparam logic [7:0]  FLASH_TICKS_RST = 8'd2;

    // register indexes, byte address is 4 * index
    localparam int          PADDR_W          = 4;
    localparam logic [1:0]  REG_START_THR    = 2'd0;
    localparam logic [1:0]  REG_ONE_THR      = 2'd1;
    localparam logic [1:0]  REG_FLASH_TICKS  = 2'd2;

    // operation codes, OP_UNUSED has no meaning and leaves the state alone
    localparam logic [1:0] OP_SERIAL = 2'd0;
    localparam logic [1:0] OP_PULSE  = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // report kinds
    localparam logic [1:0] RPT_NONE = 2'd0;
    localparam logic [1:0] RPT_ACK  = 2'd1;
    localparam logic [1:0] RPT_IR   = 2'd2;

    // lamp codes, SEL_NONE means no lamp selected
    localparam logic [1:0] LAMP_RED    = 2'd0;
    localparam logic [1:0] LAMP_GREEN  = 2'd1;
    localparam logic [1:0] LAMP_YELLOW = 2'd2;
    localparam logic [1:0] SEL_NONE    = 2'd3;

    // serial command characters
    localparam logic [7:0] CH_R    = 8'h52;
    localparam logic [7:0] CH_G    = 8'h47;
    localparam logic [7:0] CH_Y    = 8'h59;
    localparam logic [7:0] CH_F    = 8'h46;
    localparam logic [7:0] CH_ONE  = 8'h31;
    localparam logic [7:0] CH_ZERO = 8'h30;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  command_byte;
        logic [15:0] pulse_width_us;
    } irled_in_t;

    typedef struct packed {
        logic [1:0]           report_kind;
        logic [1:0]           ack_lamp;
        logic                 ack_level;
        logic [IR_CODE_W-1:0] ir_code;
        logic                 red_lamp;
        logic                 green_lamp;
        logic                 yellow_lamp;
    } irled_out_t;

    typedef struct packed {
        logic [15:0] start_thr;
        logic [15:0] one_thr;
        logic [7:0]  flash_ticks;
    } irled_cfg_t;

endpackage

FILE: hw/rtl/irled_stream_if.sv
// irled_stream_if: valid/ready channel carrying one payload word
// payload type is a parameter; used with irled_pkg structs
interface irled_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/ir_and_serial_led_controller.sv
// ir_and_serial_led_controller: top level, lamp control from serial bytes,
// pulse-width ir codes and timer ticks; depends on irled_pkg, irled_stream_if, irled_cfg
//
// usage:
//   in_ch carries one event word: a serial byte, an ir low-pulse width or a timer tick.
//   out_ch returns exactly one result word per event: the report (ack or ir code)
//   and the three lamp drive levels after the event.
//   the apb port sets the start and one-bit thresholds and the flash length;
//   write it only while no event is in flight.
// timing:
//   an accepted event waits in the input register; the lamp state and the result
//   register update together when it advances, that is when the result register is
//   empty or being taken. one event per cycle is sustained while out_ch is not
//   stalled; the state update is a few compares and small register writes.
// stalls:
//   while out_ch is stalled the result register holds and the input register can
//   still take one more event; in_ch.ready drops only when both are full.
// reset:
//   rst_n clears the lamps, selection, flash and ir receiver, empties both
//   registers and restores the register defaults.
module ir_and_serial_led_controller #(
    parameter int CODE_BITS = irled_pkg::CODE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    irled_stream_if.sink                  in_ch,
    irled_stream_if.source                out_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [irled_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import irled_pkg::*;

    localparam int IDX_W = (CODE_BITS > 1) ? $clog2(CODE_BITS) : 1;

    irled_cfg_t cfg;

    // input register
    logic      item_valid_reg;
    irled_in_t item_reg;
    // result register
    logic       res_valid_reg;
    irled_out_t res_reg;
    irled_out_t res_next;

    // lamp and receiver state
    logic [1:0]           sel_reg,     sel_next;
    logic                 latched_reg, latched_next;
    logic                 flash_reg,   flash_next;
    logic [7:0]           count_reg,   count_next;
    logic                 red_reg,     red_next;
    logic                 green_reg,   green_next;
    logic                 yellow_reg,  yellow_next;
    logic                 rx_reg,      rx_next;
    logic [IDX_W-1:0]     idx_reg,     idx_next;
    logic [CODE_BITS-1:0] acc_reg,     acc_next;

    logic [CODE_BITS+IR_CODE_W-1:0] acc_ext;
    logic                           advance;

    irled_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign advance      = item_valid_reg & (~res_valid_reg | out_ch.ready);
    assign in_ch.ready  = ~item_valid_reg | advance;
    assign out_ch.valid = res_valid_reg;
    assign out_ch.data  = res_reg;

    always_comb
    begin
        sel_next     = sel_reg;
        latched_next = latched_reg;
        flash_next   = flash_reg;
        count_next   = count_reg;
        red_next     = red_reg;
        green_next   = green_reg;
        yellow_next  = yellow_reg;
        rx_next      = rx_reg;
        idx_next     = idx_reg;
        acc_next     = acc_reg;
        acc_ext      = '0;
        res_next     = '0;

        case (item_reg.operation)
            OP_SERIAL:
            begin
                case (item_reg.command_byte) inside
                    CH_R: sel_next = LAMP_RED;
                    CH_G: sel_next = LAMP_GREEN;
                    CH_Y: sel_next = LAMP_YELLOW;
                    CH_ONE, CH_ZERO:
                    begin
                        if (sel_reg != SEL_NONE)
                        begin
                            res_next.report_kind = RPT_ACK;
                            res_next.ack_lamp    = sel_reg;
                            res_next.ack_level   = (item_reg.command_byte == CH_ONE);
                            case (sel_reg)
                                LAMP_RED:
                                begin
                                    red_next     = res_next.ack_level;
                                    latched_next = res_next.ack_level;
                                end
                                LAMP_GREEN: green_next  = res_next.ack_level;
                                default:    yellow_next = res_next.ack_level;
                            endcase
                            sel_next = SEL_NONE;
                        end
                    end
                    CH_F:
                    begin
                        if (!latched_reg)
                        begin
                            red_next   = 1'b1;
                            flash_next = 1'b1;
                            count_next = 8'd0;
                        end
                    end
                    default: sel_next = SEL_NONE;
                endcase
            end
            OP_PULSE:
            begin
                if (!rx_reg)
                begin
                    if (item_reg.pulse_width_us > cfg.start_thr)
                    begin
                        rx_next  = 1'b1;
                        idx_next = '0;
                        acc_next = '0;
                    end
                end
                else
                begin
                    if (item_reg.pulse_width_us > cfg.one_thr)
                        acc_next[idx_reg] = 1'b1;
                    if (idx_reg == IDX_W'(CODE_BITS - 1))
                    begin
                        rx_next  = 1'b0;
                        idx_next = '0;
                        if (acc_next != '0)
                        begin
                            acc_ext              = {{IR_CODE_W{1'b0}}, acc_next};
                            res_next.report_kind = RPT_IR;
                            res_next.ir_code     = acc_ext[IR_CODE_W-1:0];
                            if (!latched_reg)
                            begin
                                red_next   = 1'b1;
                                flash_next = 1'b1;
                                count_next = 8'd0;
                            end
                        end
                        acc_next = '0;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            OP_TICK:
            begin
                // flash ticks are frozen while red is latched on
                if (!latched_reg && flash_reg)
                begin
                    count_next = count_reg + 8'd1;
                    if (count_next == cfg.flash_ticks)
                    begin
                        red_next   = 1'b0;
                        flash_next = 1'b0;
                    end
                end
            end
            default: ;
        endcase

        res_next.red_lamp    = red_next;
        res_next.green_lamp  = green_next;
        res_next.yellow_lamp = yellow_next;
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            sel_reg        <= SEL_NONE;
            latched_reg    <= 1'b0;
            flash_reg      <= 1'b0;
            count_reg      <= 8'd0;
            red_reg        <= 1'b0;
            green_reg      <= 1'b0;
            yellow_reg     <= 1'b0;
            rx_reg         <= 1'b0;
            idx_reg        <= '0;
            acc_reg        <= '0;
        end
        else
        begin
            if (in_ch.ready)
                item_valid_reg <= in_ch.valid;
            if (advance)
                res_valid_reg <= 1'b1;
            else if (out_ch.ready)
                res_valid_reg <= 1'b0;
            if (advance)
            begin
                sel_reg     <= sel_next;
                latched_reg <= latched_next;
                flash_reg   <= flash_next;
                count_reg   <= count_next;
                red_reg     <= red_next;
                green_reg   <= green_next;
                yellow_reg  <= yellow_next;
                rx_reg      <= rx_next;
                idx_reg     <= idx_next;
                acc_reg     <= acc_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
            item_reg <= in_ch.data;
        if (advance)
            res_reg <= res_next;
    end

endmodule

FILE: hw/rtl/irled_cfg.sv
// irled_cfg: apb-style register block holding the thresholds and flash length
// depends on irled_pkg
module irled_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [irled_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output irled_pkg::irled_cfg_t          cfg
);
    import irled_pkg::*;

    irled_cfg_t cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_thr   <= START_THR_RST;
            cfg_reg.one_thr     <= ONE_THR_RST;
            cfg_reg.flash_ticks <= FLASH_TICKS_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_START_THR:   cfg_reg.start_thr   <= pwdata[15:0];
                REG_ONE_THR:     cfg_reg.one_thr     <= pwdata[15:0];
                REG_FLASH_TICKS: cfg_reg.flash_ticks <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_START_THR:   prdata = {16'd0, cfg_reg.start_thr};
            REG_ONE_THR:     prdata = {16'd0, cfg_reg.one_thr};
            REG_FLASH_TICKS: prdata = {24'd0, cfg_reg.flash_ticks};
            default:         prdata = 32'd0;
        endcase
    end

endmodule

FILE: hw/rtl/irled_checker.sv
// irled_checker: port-level assertions on the result channel of the controller
// depends on irled_pkg; bound to ir_and_serial_led_controller below
module irled_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  out_valid,
    input logic                  out_ready,
    input irled_pkg::irled_out_t out_data
);
    import irled_pkg::*;

    // a stalled result word stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");

    // ack fields are zero unless an ack is reported
    a_ack_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.report_kind != RPT_ACK |->
            out_data.ack_lamp == LAMP_RED && !out_data.ack_level)
        else $error("ack fields set without ack");

    // ir code is zero unless a code is reported, and a reported code is nonzero
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_data.report_kind == RPT_IR) == (out_data.ir_code != '0)))
        else $error("ir code and report kind disagree");

    // a received code always leaves red lit (flash or latched on)
    a_ir_red: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.report_kind == RPT_IR |-> out_data.red_lamp)
        else $error("ir code reported with red off");

    // an acknowledged red command shows at once on the red lamp
    a_red_ack: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.report_kind == RPT_ACK && out_data.ack_lamp == LAMP_RED |->
            out_data.red_lamp == out_data.ack_level)
        else $error("red ack does not match red lamp");

endmodule

bind ir_and_serial_led_controller irled_checker u_irled_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
);

FILE: sim/ir_and_serial_led_controller_tb.sv
// testbench for ir_and_serial_led_controller: serial lamp commands, ir pulse frames and ticks
// are driven on in_ch, every result word on out_ch is checked against a built-in lamp predictor
// depends on irled_pkg, irled_stream_if and the rtl top level
module ir_and_serial_led_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import irled_pkg::*;

    localparam int CODE_LEN   = 12;
    localparam int HOLD_LEN   = 60;
    localparam int IDLE_LIMIT = 3000;

    // lamp state predictor plus the queue of result words still owed by the block
    class lamp_scoreboard;
        logic [15:0] start_thr;
        logic [15:0] one_thr;
        logic [7:0]  flash_len;

        logic [1:0]  sel;
        bit          red_latched;
        bit          flash_on;
        logic [7:0]  flash_cnt;
        bit          red;
        bit          green;
        bit          yellow;
        bit          ir_busy;
        int          bit_idx;
        logic [11:0] ir_acc;

        irled_out_t  expected_lamp_results[$];
        int unsigned failures;

        function new();
            start_thr   = START_THR_RST;
            one_thr     = ONE_THR_RST;
            flash_len   = FLASH_TICKS_RST;
            sel         = SEL_NONE;
            red_latched = 0;
            flash_on    = 0;
            flash_cnt   = '0;
            red         = 0;
            green       = 0;
            yellow      = 0;
            ir_busy     = 0;
            bit_idx     = 0;
            ir_acc      = '0;
            failures    = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_START_THR:   start_thr = val[15:0];
                REG_ONE_THR:     one_thr = val[15:0];
                REG_FLASH_TICKS: flash_len = val[7:0];
                default: ;
            endcase
        endfunction

        // red latched on by command blocks any flash
        function void start_flash();
            if (!red_latched)
            begin
                red       = 1;
                flash_on  = 1;
                flash_cnt = '0;
            end
        endfunction

        function void note_event(irled_in_t ev);
            irled_out_t r;
            r = '0;
            case (ev.operation)
                OP_SERIAL:
                begin
                    case (ev.command_byte)
                        CH_R: sel = LAMP_RED;
                        CH_G: sel = LAMP_GREEN;
                        CH_Y: sel = LAMP_YELLOW;
                        CH_ONE, CH_ZERO:
                        begin
                            if (sel != SEL_NONE)
                            begin
                                r.report_kind = RPT_ACK;
                                r.ack_lamp    = sel;
                                r.ack_level   = (ev.command_byte == CH_ONE);
                                case (sel)
                                    LAMP_RED:
                                    begin
                                        red         = r.ack_level;
                                        red_latched = r.ack_level;
                                    end
                                    LAMP_GREEN: green = r.ack_level;
                                    default:    yellow = r.ack_level;
                                endcase
                                sel = SEL_NONE;
                            end
                        end
                        CH_F:    start_flash();
                        default: sel = SEL_NONE;
                    endcase
                end
                OP_PULSE:
                begin
                    if (!ir_busy)
                    begin
                        if (ev.pulse_width_us > start_thr)
                        begin
                            ir_busy = 1;
                            bit_idx = 0;
                            ir_acc  = '0;
                        end
                    end
                    else
                    begin
                        if (ev.pulse_width_us > one_thr)
                            ir_acc[bit_idx] = 1'b1;
                        bit_idx++;
                        if (bit_idx >= CODE_LEN)
                        begin
                            ir_busy = 0;
                            bit_idx = 0;
                            if (ir_acc != '0)
                            begin
                                r.report_kind = RPT_IR;
                                r.ir_code     = ir_acc;
                                start_flash();
                            end
                            ir_acc = '0;
                        end
                    end
                end
                OP_TICK:
                begin
                    // ticks are frozen while red is latched
                    if (!red_latched && flash_on)
                    begin
                        flash_cnt++;
                        if (flash_cnt == flash_len)
                        begin
                            red      = 0;
                            flash_on = 0;
                        end
                    end
                end
                default: ;
            endcase
            r.red_lamp    = red;
            r.green_lamp  = green;
            r.yellow_lamp = yellow;
            expected_lamp_results.push_back(r);
        endfunction

        function string fmt(irled_out_t w);
            return $sformatf("kind %0d lamp %0d level %0d code %03h r%0d g%0d y%0d",
                             w.report_kind, w.ack_lamp, w.ack_level, w.ir_code,
                             w.red_lamp, w.green_lamp, w.yellow_lamp);
        endfunction

        function void flag_failure(string msg);
            failures++;
            if (failures <= 10)
                $display("%s", msg);
        endfunction

        function void check_result(irled_out_t got);
            irled_out_t exp;
            if (expected_lamp_results.size() == 0)
                flag_failure({"unexpected word: ", fmt(got)});
            else
            begin
                exp = expected_lamp_results.pop_front();
                if (got.report_kind !== exp.report_kind || got.ack_lamp !== exp.ack_lamp ||
                    got.ack_level !== exp.ack_level || got.ir_code !== exp.ir_code ||
                    got.red_lamp !== exp.red_lamp || got.green_lamp !== exp.green_lamp ||
                    got.yellow_lamp !== exp.yellow_lamp)
                    flag_failure({"mismatch: expected ", fmt(exp), ", got ", fmt(got)});
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    irled_stream_if #(.payload_t(irled_in_t))  in_ch ();
    irled_stream_if #(.payload_t(irled_out_t)) out_ch ();

    ir_and_serial_led_controller uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    lamp_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int events_sent;
    int stall_requests;
    int stall_served;
    int hold_left;
    int idle_cycles;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // receiver: random stalls, plus a long hold-off whenever one is requested
    always @(negedge clk)
    begin
        if (stall_served != stall_requests)
        begin
            stall_served = stall_requests;
            hold_left    = HOLD_LEN;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                sb.note_event(in_ch.data);
            if (out_ch.valid && out_ch.ready)
                sb.check_result(out_ch.data);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
                $display("[ir_and_serial_led_controller] ERROR");
                $finish;
            end
        end
    end

    function automatic irled_in_t make_event(logic [1:0] op, logic [7:0] ch, logic [15:0] w);
        irled_in_t ev;
        ev.operation      = op;
        ev.command_byte   = ch;
        ev.pulse_width_us = w;
        return ev;
    endfunction

    // a width strictly above the threshold (if possible) or at most the threshold
    function automatic logic [15:0] width_vs(logic [15:0] thr, bit above);
        logic [15:0] w;
        if (!above)
            w = 16'($urandom_range(thr, 0));
        else if (thr == 16'hFFFF)
            w = 16'hFFFF;
        else
            w = 16'($urandom_range(65535, thr + 1));
        return w;
    endfunction

    task automatic send_event(irled_in_t ev);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= ev;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        events_sent++;
    endtask

    task automatic send_serial(logic [7:0] ch);
        send_event(make_event(OP_SERIAL, ch, '0));
    endtask

    task automatic send_pulse(logic [15:0] w);
        send_event(make_event(OP_PULSE, '0, w));
    endtask

    task automatic send_tick();
        send_event(make_event(OP_TICK, 8'($urandom), 16'($urandom)));
    endtask

    // start pulse then the code lsb first, with ticks or bytes slipped in between bits
    task automatic send_ir_frame(logic [11:0] code, int noise_pct);
        int i;
        send_pulse(width_vs(sb.start_thr, 1'b1));
        for (i = 0; i < CODE_LEN; i++)
        begin
            if ($urandom_range(99) < noise_pct)
            begin
                if ($urandom_range(1) == 0)
                    send_tick();
                else
                    send_serial(8'($urandom));
            end
            send_pulse(width_vs(sb.one_thr, code[i]));
        end
    endtask

    task automatic drain();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (sb.expected_lamp_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_register(idx, val);
    endtask

    task automatic configure(logic [15:0] start_thr, logic [15:0] one_thr, logic [7:0] ticks);
        drain();
        write_reg(REG_START_THR, {16'd0, start_thr});
        write_reg(REG_ONE_THR, {16'd0, one_thr});
        write_reg(REG_FLASH_TICKS, {24'd0, ticks});
    endtask

    task automatic random_step();
        int pick;
        logic [7:0] letters[3];
        logic [11:0] code;
        letters = '{CH_R, CH_G, CH_Y};
        pick = $urandom_range(99);
        if (pick < 30)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
            begin
                send_serial(letters[$urandom_range(2)]);
                if ($urandom_range(9) == 0)
                    send_serial(CH_F);
                send_serial($urandom_range(1) ? CH_ONE : CH_ZERO);
            end
            else if (pick < 70)
                send_serial(CH_F);
            else if (pick < 85)
                send_serial($urandom_range(1) ? CH_ONE : CH_ZERO);
            else
                send_serial(8'($urandom));
        end
        else if (pick < 50)
        begin
            code = ($urandom_range(9) == 0) ? 12'h000 : 12'($urandom);
            send_ir_frame(code, 10);
        end
        else if (pick < 75)
            send_tick();
        else if (pick < 85)
            send_pulse(16'($urandom));
        else
            send_event(irled_in_t'($urandom));
    endtask

    task automatic run_random(int count);
        int stop;
        stop = events_sent + count;
        while (events_sent < stop)
            random_step();
    endtask

    initial
    begin
        sb             = new();
        rst_n          = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.data     = '0;
        out_ch.ready   = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        events_sent    = 0;
        stall_requests = 0;
        stall_served   = 0;
        hold_left      = 0;
        idle_cycles    = 0;
        send_idle_pct  = 21;
        recv_idle_pct  = 74;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: level byte with nothing selected, dead operation code
        send_serial(CH_ONE);
        send_event(make_event(OP_UNUSED, 8'hFF, 16'hFFFF));
        // red latched on blocks a flash, then released
        send_serial(CH_R);
        send_serial(CH_ONE);
        send_serial(CH_F);
        send_tick();
        send_serial(CH_R);
        send_serial(CH_ZERO);
        send_serial(CH_G);
        send_serial(CH_ONE);
        send_serial(CH_Y);
        send_serial(CH_ONE);
        // unknown byte drops the selection
        send_serial(CH_Y);
        send_serial(8'h00);
        send_serial(CH_ZERO);
        // flash keeps the selection, two ticks end the flash
        send_serial(CH_G);
        send_serial(CH_F);
        send_serial(CH_ZERO);
        send_tick();
        send_tick();
        // short pulses while idle, then a full code with noise
        send_pulse(16'h0000);
        send_pulse(START_THR_RST);
        send_ir_frame(12'hFFF, 20);
        run_random(30);

        send_idle_pct = 74;
        recv_idle_pct = 21;
        configure(16'h0000, 16'h0000, 8'd1);
        run_random(30);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        configure(16'hFFFF, 16'hFFFF, 8'd255);
        run_random(10);
        configure(16'($urandom), 16'($urandom_range(40000, 0)), 8'd0);
        // count wraps: with zero ticks the flash lasts 256 ticks
        send_serial(CH_R);
        send_serial(CH_ZERO);
        send_serial(CH_F);
        repeat (256) send_tick();
        run_random(10);
        stall_requests++;
        run_random(20);

        drain();
        repeat (8) @(negedge clk);
        if (sb.expected_lamp_results.size() != 0)
            sb.flag_failure($sformatf("%0d result words never arrived",
                                      sb.expected_lamp_results.size()));
        if (sb.failures == 0)
            $display("[ir_and_serial_led_controller] OK");
        else
            $display("[ir_and_serial_led_controller] ERROR");
        $finish;
    end

endmodule

FILE: ir_and_serial_led_controller.f
hw/rtl/irled_pkg.sv
hw/rtl/irled_stream_if.sv
hw/rtl/irled_cfg.sv
hw/rtl/ir_and_serial_led_controller.sv
hw/rtl/irled_checker.sv
sim/ir_and_serial_led_controller_tb.sv
